### design/dqe_pkg.sv
package dqe_pkg;

  // Word width of the stored values and width of the reported occupancy.
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  // Command codes.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PUSH_FRONT = 2'd0;
  localparam cmd_t CMD_PUSH_BACK  = 2'd1;
  localparam cmd_t CMD_POP_FRONT  = 2'd2;
  localparam cmd_t CMD_POP_BACK   = 2'd3;

  // Control record that the front part hands to the back part for each command.
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic             success;
    logic [OCC_W-1:0] occupancy;
    logic             full;
    logic             empty;
  } ctl_t;

  // One result beat.
  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     success;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_full_flag;
    logic                     is_empty_flag;
  } res_t;

endpackage

### design/dqe_fifo.sv
module dqe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and count updates with wrap at the last slot.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### design/dqe_front.sv
module dqe_front #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  dqe_pkg::cmd_t          command,
  output dqe_pkg::ctl_t          ctl,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   sum_tail, sum_last;
  logic [AW-1:0] tail_slot, last_slot;
  logic          is_full, is_empty, ok, wr, rd;

  assign is_full  = (count_r == DEPTH_C);
  assign is_empty = (count_r == '0);

  // Slot past the back word, and slot of the back word, both wrapped once.
  assign sum_tail  = (CW + 1)'(front_r) + (CW + 1)'(count_r);
  assign sum_last  = sum_tail - (CW + 1)'(1);
  assign tail_slot = AW'((sum_tail >= DEPTH_S) ? sum_tail - DEPTH_S : sum_tail);
  assign last_slot = AW'((sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last);

  // Classify the command and work out the new front index and count.
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    ok        = 1'b0;
    wr        = 1'b0;
    rd        = 1'b0;
    slot      = front_r;
    case (command)
      dqe_pkg::CMD_PUSH_FRONT: begin
        ok   = !is_full;
        wr   = ok;
        slot = (front_r == '0) ? LAST : front_r - AW'(1);
        if (ok) begin
          front_nxt = slot;
          count_nxt = count_r + CW'(1);
        end
      end
      dqe_pkg::CMD_PUSH_BACK: begin
        ok   = !is_full;
        wr   = ok;
        slot = tail_slot;
        if (ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      dqe_pkg::CMD_POP_FRONT: begin
        ok   = !is_empty;
        rd   = ok;
        slot = front_r;
        if (ok) begin
          front_nxt = (front_r == LAST) ? '0 : front_r + AW'(1);
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        ok   = !is_empty;
        rd   = ok;
        slot = last_slot;
        if (ok) begin
          count_nxt = count_r - CW'(1);
        end
      end
    endcase
  end

  // Control record for the back part.
  always_comb begin
    ctl.wr        = wr;
    ctl.rd        = rd;
    ctl.success   = ok;
    ctl.occupancy = dqe_pkg::OCC_W'(count_nxt);
    ctl.full      = (count_nxt == DEPTH_C);
    ctl.empty     = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (acc) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("occupancy count exceeds capacity");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ok |=> $stable(count_r) && $stable(front_r))
    else $error("refused command changed the queue state");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    acc && rd |=> count_r == $past(count_r) - CW'(1))
    else $error("successful pop did not lower the count by one");
`endif

endmodule

### design/dqe_back.sv
module dqe_back #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cq_valid,
  input  dqe_pkg::ctl_t              ctl,
  input  logic [$clog2(DEPTH)-1:0]   slot,
  input  logic [dqe_pkg::WORD_W-1:0] wdata,
  output logic                       cq_pop,
  input  logic                       oq_full,
  output logic                       oq_push,
  output dqe_pkg::res_t              res
);

  logic [dqe_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic [dqe_pkg::WORD_W-1:0] rd_data_r;
  dqe_pkg::ctl_t              s1_ctl_r;
  logic                       s1_v_r, s1_v_nxt;
  logic                       issue;

  // Issue a command when the result stage is free or drains this cycle.
  assign issue   = cq_valid && (!s1_v_r || !oq_full);
  assign cq_pop  = issue;
  assign oq_push = s1_v_r && !oq_full;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue) begin
      s1_v_nxt = 1'b1;
    end else if (oq_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Word store: one write or one registered read per command.
  always_ff @(posedge clk) begin
    if (issue && ctl.wr) begin
      mem_r[slot] <= wdata;
    end
    if (issue && ctl.rd) begin
      rd_data_r <= mem_r[slot];
    end
    if (issue) begin
      s1_ctl_r <= ctl;
    end
  end

  // Result beat; the popped word is zero unless a pop succeeded.
  always_comb begin
    res.popped_value  = s1_ctl_r.rd ? rd_data_r : '0;
    res.success       = s1_ctl_r.success;
    res.occupancy     = s1_ctl_r.occupancy;
    res.is_full_flag  = s1_ctl_r.full;
    res.is_empty_flag = s1_ctl_r.empty;
  end

`ifndef SYNTHESIS
  a_issue_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s1_v_r)
    else $error("issued command did not reach the result stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && oq_full |=> s1_v_r && $stable(s1_ctl_r))
    else $error("result stage changed while the result queue was full");
`endif

endmodule

### design/double_ended_queue_top.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------------
// command   | in_push / in_full     | in_command, in_push_value
// result    | out_pop / out_empty   | out_popped_value, out_success, out_occupancy,
//           |                       | out_is_full_flag, out_is_empty_flag
//
// Sustained rate is one command per cycle while the result queue does not fill; each
// command gives one result beat. An accepted command passes through the command queue,
// the result stage with the registered word-store read, and the result queue to the ports.
// Reset (rst_n low, synchronous) empties the deque and both queues; stored words are
// not cleared. A full result queue stalls the back part and, once the command
// queue fills, raises in_full.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  dqe_pkg::cmd_t                     in_command,
  input  logic signed [dqe_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [dqe_pkg::WORD_W-1:0] out_popped_value,
  output logic                              out_success,
  output logic [dqe_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_is_full_flag,
  output logic                              out_is_empty_flag
);

  localparam int AW    = $clog2(DEPTH);
  localparam int REC_W = $bits(dqe_pkg::ctl_t) + AW + dqe_pkg::WORD_W;
  localparam int RES_W = $bits(dqe_pkg::res_t);

  logic                       acc;
  dqe_pkg::ctl_t              f_ctl, cq_ctl;
  logic [AW-1:0]              f_slot, cq_slot;
  logic [dqe_pkg::WORD_W-1:0] cq_data;
  logic [REC_W-1:0]           cq_din, cq_dout;
  logic                       cq_full, cq_empty, cq_pop;
  logic                       oq_full, oq_push;
  dqe_pkg::res_t              b_res, oq_res;
  logic [RES_W-1:0]           oq_dout;

  assign acc     = in_push && !cq_full;
  assign in_full = cq_full;

  dqe_front #(.DEPTH(DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .command (in_command),
    .ctl     (f_ctl),
    .slot    (f_slot)
  );

  // Command queue between the front and back parts.
  assign cq_din = {f_ctl, f_slot, in_push_value};
  assign {cq_ctl, cq_slot, cq_data} = cq_dout;

  dqe_fifo #(.WIDTH(REC_W), .DEPTH(2)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc),
    .din   (cq_din),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .full  (cq_full),
    .empty (cq_empty)
  );

  dqe_back #(.DEPTH(DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_valid (!cq_empty),
    .ctl      (cq_ctl),
    .slot     (cq_slot),
    .wdata    (cq_data),
    .cq_pop   (cq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .res      (b_res)
  );

  // Result queue toward the consumer.
  dqe_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (b_res),
    .pop   (out_pop),
    .dout  (oq_dout),
    .full  (oq_full),
    .empty (out_empty)
  );

  assign oq_res            = oq_dout;
  assign out_popped_value  = oq_res.popped_value;
  assign out_success       = oq_res.success;
  assign out_occupancy     = oq_res.occupancy;
  assign out_is_full_flag  = oq_res.is_full_flag;
  assign out_is_empty_flag = oq_res.is_empty_flag;

endmodule
